[src/sks_pkg.sv]
// Shared types, constants and helper functions of the soft keyboard event scanner.
// Used by the front, queue, back and top level modules; depends on nothing.
package sks_pkg;

  // Key map
  localparam int KEY_COUNT  = 54;
  localparam int KEY_W      = 6;
  localparam int GRID_KEYS  = 40;
  localparam int KEY_CONFIG = 41;
  localparam int LOW_KEYS   = KEY_CONFIG + 1;
  localparam int BUTTONS    = 12;
  localparam logic [KEY_W-1:0] NO_KEY = KEY_W'(KEY_COUNT);

  // Touch grid geometry, in pixels
  localparam int BAND_TOP    = 21;
  localparam int BAND_BOTTOM = 165;
  localparam int GRID_TOP    = 36;
  localparam int X_LEFT      = 2;
  localparam int COL_PITCH   = 25;
  localparam int ROW_PITCH   = 30;
  localparam int KEY_HEIGHT  = 17;
  localparam int GRID_COLS   = 10;
  localparam int GRID_ROWS   = 4;

  // Register reset values and widths
  localparam int TGT_W = 36;
  localparam logic [TGT_W-1:0] PAD_FIRST_RESET  = 36'd31291359558;
  localparam logic [TGT_W-1:0] PAD_SECOND_RESET = 36'd58902408630;

  // Default depth of the poll queue
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CFG_STICKY     = 2'd0,
    CFG_PAD_FIRST  = 2'd1,
    CFG_PAD_SECOND = 2'd2
  } cfg_index_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SCAN = 1'b1
  } back_state_e;

  // One classified poll: which keys changed and their new down bits
  typedef struct packed {
    logic [KEY_COUNT-1:0] changed;
    logic [KEY_COUNT-1:0] down;
  } poll_t;

  // Button index that owns pad key k (k from 42 upward)
  function automatic int own_button(input int k);
    own_button = (k >= 46) ? (k - 46) : (k - 42 + 8);
  endfunction

  // Key under a touch point on the grid, or NO_KEY on a miss
  function automatic logic [KEY_W-1:0] locate(input logic [7:0] x, input logic [7:0] y);
    logic [7:0]       xm;
    logic [7:0]       d;
    logic [7:0]       rowoff;
    logic [7:0]       rem;
    logic [3:0]       col;
    logic [2:0]       row;
    logic [KEY_W-1:0] key;
    xm  = x - 8'(X_LEFT + 1);
    d   = y - 8'(GRID_TOP + 1);
    col = '0;
    row = '0;
    for (int i = 1; i <= GRID_COLS; i++) begin
      if (xm >= 8'(COL_PITCH * i)) col = col + 4'd1;
    end
    for (int i = 1; i <= GRID_ROWS; i++) begin
      if (d >= 8'(ROW_PITCH * i)) row = row + 3'd1;
    end
    rowoff = 8'(row) * 8'(ROW_PITCH);
    rem    = d - rowoff;
    key    = KEY_W'(col) + KEY_W'(row) * KEY_W'(GRID_COLS);
    if (y <= 8'(GRID_TOP) || x <= 8'(X_LEFT) || col >= 4'(GRID_COLS) ||
        row >= 3'(GRID_ROWS) || rem >= 8'(KEY_HEIGHT)) begin
      locate = NO_KEY;
    end else begin
      locate = key;
    end
  endfunction

endpackage

[src/soft_keyboard_event_scanner.sv]
// Soft keyboard event scanner: a poll is taken whenever the queue has room and its new
// key state is committed at once. The back end then loads the poll and scans one key
// index per cycle up to the highest changed key, waiting at a changed key while the output
// register is full; a poll with no change gives one empty closing result instead.
// A result passes through a queue entry and the output register; output stalls delay it.
// Reset: all keys up, no key last touched, registers at reset values, queue empty.
module soft_keyboard_event_scanner #(
  parameter int QueueDepth = sks_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [sks_pkg::KEY_COUNT-1:0] cfg_data_i,
  // poll stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [11:0] buttons_held, [12] touch_held, [13] touch_ok, [21:14] touch_x,
  // [29:22] touch_y, [30] map_enable, [31] zero
  input  logic [31:0]                   s_axis_tdata,
  // event stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [5:0] key_code, [6] pressed, [7] zero
  output logic                          m_axis_tuser,  // [0] event_valid
  output logic                          m_axis_tlast   // last_event
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  sks_pkg::poll_t push_data;
  sks_pkg::poll_t pop_data;

  sks_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  sks_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  sks_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[src/sks_front.sv]
// Front end: configuration registers, key state and classification of each poll.
// Depends on sks_pkg; pushes one sks_pkg::poll_t per accepted poll.
module sks_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [sks_pkg::KEY_COUNT-1:0] cfg_data_i,
  // poll stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,
  // queue write side
  output logic                          push_o,
  output sks_pkg::poll_t                push_data_o,
  input  logic                          full_i
);

  logic [sks_pkg::KEY_COUNT-1:0] sticky_q;
  logic [sks_pkg::TGT_W-1:0]     pad_first_q;
  logic [sks_pkg::TGT_W-1:0]     pad_second_q;
  logic [sks_pkg::KEY_COUNT-1:0] key_down_q, key_down_d;
  logic [sks_pkg::KEY_W-1:0]     last_touched_q, last_touched_d;

  logic [11:0] buttons;
  logic        held;
  logic        ok;
  logic [7:0]  tx;
  logic [7:0]  ty;
  logic        map_en;
  logic        band;
  logic [sks_pkg::KEY_W-1:0]     pos;
  logic [sks_pkg::KEY_COUNT-1:0] touched;
  logic [sks_pkg::KEY_COUNT-1:0] touch_next;
  logic [sks_pkg::KEY_COUNT-1:0] pad_next;
  logic [sks_pkg::KEY_W-1:0]     tgt [sks_pkg::BUTTONS];
  logic [sks_pkg::BUTTONS-1:0]   hit;
  logic                          mapped;
  logic                          accept;

  // Unpack the poll sample
  assign buttons = s_axis_tdata[11:0];
  assign held    = s_axis_tdata[12];
  assign ok      = s_axis_tdata[13];
  assign tx      = s_axis_tdata[21:14];
  assign ty      = s_axis_tdata[29:22];
  assign map_en  = s_axis_tdata[30];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~full_i;
  assign accept        = s_axis_tvalid & ~full_i;

  // Locate the touch
  assign band = (ty < 8'(sks_pkg::BAND_TOP)) || (ty > 8'(sks_pkg::BAND_BOTTOM));
  assign pos  = sks_pkg::locate(tx, ty);

  // Apply the touch to the sticky-held low keys
  always_comb begin
    touch_next     = key_down_q & sticky_q &
                     {{(sks_pkg::KEY_COUNT-sks_pkg::LOW_KEYS){1'b0}},
                      {sks_pkg::LOW_KEYS{1'b1}}};
    touched        = '0;
    last_touched_d = last_touched_q;
    if (!held) begin
      last_touched_d = sks_pkg::NO_KEY;
    end else if (ok) begin
      if (band) begin
        touch_next[sks_pkg::KEY_CONFIG] = 1'b1;
      end else if (pos != sks_pkg::NO_KEY) begin
        touched[pos] = 1'b1;
        if (sticky_q[pos]) begin
          if (last_touched_q != pos) touch_next[pos] = ~key_down_q[pos];
        end else begin
          touch_next[pos] = 1'b1;
        end
        last_touched_d = pos;
      end
    end
  end

  // Pick each button's mapping target
  always_comb begin
    for (int b = 0; b < sks_pkg::BUTTONS; b++) begin
      if (b < 2) tgt[b] = pad_first_q[(4 + b) * 6 +: 6];
      else if (b < 8) tgt[b] = pad_second_q[(b - 2) * 6 +: 6];
      else tgt[b] = pad_first_q[(b - 8) * 6 +: 6];
      hit[b] = map_en & buttons[b] & (tgt[b] < sks_pkg::NO_KEY);
    end
  end

  // Resolve pad keys and mappings per key; a later own-key write wins over earlier mappings
  always_comb begin
    mapped = 1'b0;
    for (int k = 0; k < sks_pkg::KEY_COUNT; k++) begin
      mapped = 1'b0;
      for (int j = 0; j < sks_pkg::BUTTONS; j++) begin
        if (hit[j] && tgt[j] == sks_pkg::KEY_W'(k) && !touched[k] &&
            (k < sks_pkg::LOW_KEYS || j > sks_pkg::own_button(k))) begin
          mapped = 1'b1;
        end
      end
      if (k < sks_pkg::LOW_KEYS) begin
        pad_next[k] = touch_next[k] | mapped;
      end else begin
        pad_next[k] = buttons[sks_pkg::own_button(k)] | mapped;
      end
    end
  end

  assign key_down_d          = accept ? pad_next : key_down_q;
  assign push_o              = accept;
  assign push_data_o.changed = pad_next ^ key_down_q;
  assign push_data_o.down    = pad_next;

  // Hold key state; commit on each poll transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_down_q     <= '0;
      last_touched_q <= sks_pkg::NO_KEY;
    end else if (accept) begin
      key_down_q     <= key_down_d;
      last_touched_q <= last_touched_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sticky_q     <= '0;
      pad_first_q  <= sks_pkg::PAD_FIRST_RESET;
      pad_second_q <= sks_pkg::PAD_SECOND_RESET;
    end else if (cfg_valid_i) begin
      unique case (sks_pkg::cfg_index_e'(cfg_index_i))
        sks_pkg::CFG_STICKY:     sticky_q     <= cfg_data_i;
        sks_pkg::CFG_PAD_FIRST:  pad_first_q  <= cfg_data_i[sks_pkg::TGT_W-1:0];
        sks_pkg::CFG_PAD_SECOND: pad_second_q <= cfg_data_i[sks_pkg::TGT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/sks_queue.sv]
// Short queue of classified polls between the front and back ends.
// Depends on sks_pkg for the entry type.
module sks_queue #(
  parameter int Depth = sks_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sks_pkg::poll_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output sks_pkg::poll_t pop_data_o,
  output logic           empty_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  sks_pkg::poll_t  entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entries_q[rd_ptr_q];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) count_d = count_q + CntW'(1);
    else if (!push_i && pop_i) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[src/sks_back.sv]
// Back end: scans the changed-key mask of each queued poll and emits key events.
// Depends on sks_pkg; drives the result stream from an output register.
module sks_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  // queue read side
  input  logic           empty_i,
  input  sks_pkg::poll_t pop_data_i,
  output logic           pop_o,
  // result stream
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [7:0]     m_axis_tdata,  // [5:0] key_code, [6] pressed, [7] zero
  output logic           m_axis_tuser,  // [0] event_valid
  output logic           m_axis_tlast   // last_event
);

  sks_pkg::back_state_e state_q, state_d;

  logic [sks_pkg::KEY_COUNT-1:0] rem_q, rem_d;
  logic [sks_pkg::KEY_COUNT-1:0] down_q, down_d;
  logic [sks_pkg::KEY_W-1:0]     idx_q, idx_d;
  logic                          out_valid_q, out_valid_d;
  logic [sks_pkg::KEY_W-1:0]     out_key_q, out_key_d;
  logic                          out_pressed_q, out_pressed_d;
  logic                          out_event_q, out_event_d;
  logic                          out_last_q, out_last_d;

  logic                          out_free;
  logic [sks_pkg::KEY_COUNT-1:0] rem_cleared;
  logic                          rem_done;

  assign out_free    = ~out_valid_q | m_axis_tready;
  assign rem_cleared = rem_q & ~(sks_pkg::KEY_COUNT'(1) << idx_q);
  assign rem_done    = (rem_cleared == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sks_pkg::BK_IDLE: begin
        if (!empty_i && out_free && pop_data_i.changed != '0) state_d = sks_pkg::BK_SCAN;
      end
      sks_pkg::BK_SCAN: begin
        if (rem_q[idx_q] && out_free && rem_done) state_d = sks_pkg::BK_IDLE;
      end
      default: state_d = sks_pkg::BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    pop_o         = 1'b0;
    rem_d         = rem_q;
    down_d        = down_q;
    idx_d         = idx_q;
    out_valid_d   = out_valid_q & ~m_axis_tready;
    out_key_d     = out_key_q;
    out_pressed_d = out_pressed_q;
    out_event_d   = out_event_q;
    out_last_d    = out_last_q;
    unique case (state_q)
      sks_pkg::BK_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o  = 1'b1;
          rem_d  = pop_data_i.changed;
          down_d = pop_data_i.down;
          idx_d  = '0;
          if (pop_data_i.changed == '0) begin
            // no change: one empty closing result
            out_valid_d   = 1'b1;
            out_event_d   = 1'b0;
            out_key_d     = '0;
            out_pressed_d = 1'b0;
            out_last_d    = 1'b1;
          end
        end
      end
      sks_pkg::BK_SCAN: begin
        if (!rem_q[idx_q]) begin
          idx_d = idx_q + sks_pkg::KEY_W'(1);
        end else if (out_free) begin
          out_valid_d   = 1'b1;
          out_event_d   = 1'b1;
          out_key_d     = idx_q;
          out_pressed_d = down_q[idx_q];
          out_last_d    = rem_done;
          rem_d         = rem_cleared;
          idx_d         = idx_q + sks_pkg::KEY_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sks_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q         <= rem_d;
    down_q        <= down_d;
    idx_q         <= idx_d;
    out_key_q     <= out_key_d;
    out_pressed_q <= out_pressed_d;
    out_event_q   <= out_event_d;
    out_last_q    <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_pressed_q, out_key_q};
  assign m_axis_tuser  = out_event_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[tb/tb_soft_keyboard_event_scanner.sv]
// Self-checking testbench for the soft keyboard event scanner: drives poll samples,
// predicts the key change events and checks every result. Depends on sks_pkg and the
// soft_keyboard_event_scanner top level only.
module tb_soft_keyboard_event_scanner;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_Y         = 191;

  // One key change event as seen on the event stream
  typedef struct packed {
    logic                      valid;
    logic [sks_pkg::KEY_W-1:0] key;
    logic                      pressed;
    logic                      last;
  } key_event_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [1:0]                    cfg_index_i;
  logic [sks_pkg::KEY_COUNT-1:0] cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [31:0]                   s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [7:0]                    m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          m_axis_tlast;

  // Scanner state and registers as predicted
  logic [sks_pkg::KEY_COUNT-1:0] model_down;
  logic [sks_pkg::KEY_W-1:0]     model_last_touch;
  logic [sks_pkg::KEY_COUNT-1:0] model_sticky;
  logic [sks_pkg::TGT_W-1:0]     model_pad_first;
  logic [sks_pkg::TGT_W-1:0]     model_pad_second;

  key_event_t pending_events[$];
  key_event_t want_ev;
  int         err_count;
  int         gap_pct;
  int         stall_pct;
  int         hold_left;
  logic [7:0] prev_x;
  logic [7:0] prev_y;

  soft_keyboard_event_scanner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Free-running clock
  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // Abort a hung run
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Pack one poll sample, buttons in the lowest bits
  function automatic logic [31:0] poll_word(input logic [11:0] btn, input logic held,
                                            input logic ok, input logic [7:0] x,
                                            input logic [7:0] y, input logic map_en);
    return {1'b0, map_en, y, x, ok, held, btn};
  endfunction

  // Grid key under a touch point, NO_KEY on a miss
  function automatic logic [sks_pkg::KEY_W-1:0] grid_key(input int x, input int y);
    int col;
    int row;
    int d;
    if (y <= sks_pkg::GRID_TOP || x <= sks_pkg::X_LEFT) return sks_pkg::NO_KEY;
    col = (x - sks_pkg::X_LEFT - 1) / sks_pkg::COL_PITCH;
    d   = y - sks_pkg::GRID_TOP - 1;
    row = d / sks_pkg::ROW_PITCH;
    if (d % sks_pkg::ROW_PITCH >= sks_pkg::KEY_HEIGHT || col >= sks_pkg::GRID_COLS)
      return sks_pkg::NO_KEY;
    if (col + row * sks_pkg::GRID_COLS >= sks_pkg::GRID_KEYS) return sks_pkg::NO_KEY;
    return sks_pkg::KEY_W'(col + row * sks_pkg::GRID_COLS);
  endfunction

  // Pad key driven by button bit b
  function automatic int pad_own_key(input int b);
    return (b < 8) ? 46 + b : 42 + (b - 8);
  endfunction

  // Mapped target of button bit b
  function automatic int pad_target(input int b);
    if (b < 2) return int'(model_pad_first[(4 + b) * 6 +: 6]);
    if (b < 8) return int'(model_pad_second[(b - 2) * 6 +: 6]);
    return int'(model_pad_first[(b - 8) * 6 +: 6]);
  endfunction

  // Work out the new down bits of one poll and queue its change events
  function automatic void scan_poll(input logic [31:0] word);
    logic [11:0]                   btn;
    logic                          held;
    logic                          ok;
    logic                          map_en;
    logic [7:0]                    x;
    logic [7:0]                    y;
    logic [sks_pkg::KEY_COUNT-1:0] nxt;
    logic [sks_pkg::KEY_COUNT-1:0] touched;
    logic [sks_pkg::KEY_COUNT-1:0] changed;
    logic [sks_pkg::KEY_W-1:0]     hit;
    key_event_t                    ev;
    int                            b;
    int                            k;
    int                            tgt;
    int                            n;
    btn     = word[11:0];
    held    = word[12];
    ok      = word[13];
    x       = word[21:14];
    y       = word[29:22];
    map_en  = word[30];
    nxt     = model_down & model_sticky &
              ((sks_pkg::KEY_COUNT'(1) << sks_pkg::LOW_KEYS) - sks_pkg::KEY_COUNT'(1));
    touched = '0;
    if (held) begin
      if (ok) begin
        if (y < sks_pkg::BAND_TOP || y > sks_pkg::BAND_BOTTOM) begin
          nxt[sks_pkg::KEY_CONFIG] = 1'b1;
        end else begin
          hit = grid_key(int'(x), int'(y));
          if (hit != sks_pkg::NO_KEY) begin
            touched[hit] = 1'b1;
            if (model_sticky[hit]) begin
              // toggle only on a fresh touch
              if (model_last_touch != hit) nxt[hit] = ~model_down[hit];
            end else begin
              nxt[hit] = 1'b1;
            end
            model_last_touch = hit;
          end
        end
      end
    end else begin
      model_last_touch = sks_pkg::NO_KEY;
    end
    for (b = 0; b < sks_pkg::BUTTONS; b++) begin
      tgt = pad_target(b);
      nxt[pad_own_key(b)] = btn[b];
      if (map_en && btn[b] && tgt < sks_pkg::KEY_COUNT && !touched[tgt]) nxt[tgt] = 1'b1;
    end
    changed = nxt ^ model_down;
    n = 0;
    for (k = 0; k < sks_pkg::KEY_COUNT; k++) begin
      if (changed[k]) begin
        ev = '{valid: 1'b1, key: sks_pkg::KEY_W'(k), pressed: nxt[k], last: 1'b0};
        pending_events.push_back(ev);
        n++;
      end
    end
    if (n == 0) begin
      ev = '{valid: 1'b0, key: '0, pressed: 1'b0, last: 1'b1};
      pending_events.push_back(ev);
    end else begin
      pending_events[$].last = 1'b1;
    end
    model_down = nxt;
  endfunction

  // Random six-slot target word, mostly real keys
  function automatic logic [sks_pkg::TGT_W-1:0] random_targets();
    logic [sks_pkg::TGT_W-1:0] v;
    int                        s;
    v = '0;
    for (s = 0; s < 6; s++) begin
      v[s * 6 +: 6] = ($urandom_range(0, 99) < 80)
                      ? 6'($urandom_range(0, sks_pkg::KEY_COUNT - 1))
                      : 6'($urandom_range(sks_pkg::KEY_COUNT, 63));
    end
    return v;
  endfunction

  // Random poll: mostly touches on grid keys, held points and releases, some noise
  function automatic logic [31:0] random_poll();
    int          r;
    int          key;
    logic        held;
    logic        ok;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [11:0] btn;
    r    = $urandom_range(0, 99);
    held = 1'b1;
    ok   = 1'b1;
    x    = prev_x;
    y    = prev_y;
    if (r < 45) begin
      key = $urandom_range(0, sks_pkg::GRID_KEYS - 1);
      x = 8'(sks_pkg::X_LEFT + 1 + (key % sks_pkg::GRID_COLS) * sks_pkg::COL_PITCH +
             $urandom_range(0, sks_pkg::COL_PITCH - 1));
      y = 8'(sks_pkg::GRID_TOP + 1 + (key / sks_pkg::GRID_COLS) * sks_pkg::ROW_PITCH +
             $urandom_range(0, sks_pkg::KEY_HEIGHT - 1));
    end else if (r < 65) begin
      // hold the previous point
    end else if (r < 77) begin
      held = 1'b0;
      ok   = 1'($urandom_range(0, 1));
      x    = 8'($urandom_range(0, 255));
      y    = 8'($urandom_range(0, MAX_Y));
    end else if (r < 85) begin
      x = 8'($urandom_range(0, 255));
      y = $urandom_range(0, 1) ? 8'($urandom_range(0, sks_pkg::BAND_TOP - 1))
                               : 8'($urandom_range(sks_pkg::BAND_BOTTOM + 1, MAX_Y));
    end else if (r < 92) begin
      ok = 1'b0;
      x  = 8'($urandom_range(0, 255));
      y  = 8'($urandom_range(0, MAX_Y));
    end else begin
      held = 1'($urandom_range(0, 1));
      ok   = 1'($urandom_range(0, 1));
      x    = 8'($urandom_range(0, 255));
      y    = 8'($urandom_range(0, MAX_Y));
    end
    prev_x = x;
    prev_y = y;
    btn = ($urandom_range(0, 3) == 0) ? 12'h000 : 12'($urandom_range(0, 4095));
    return poll_word(btn, held, ok, x, y, $urandom_range(0, 3) != 0);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    err_count++;
  endtask

  // Offer one poll after a random gap and predict it on its transaction
  task automatic send_poll(input logic [31:0] word);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = word;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_poll(word);
  endtask

  // Drop the poll stream, wait for every expected event, then let the block settle
  task automatic wait_drain(input int settle);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(input sks_pkg::cfg_index_e idx,
                           input logic [sks_pkg::KEY_COUNT-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sks_pkg::CFG_STICKY:     model_sticky     = value;
      sks_pkg::CFG_PAD_FIRST:  model_pad_first  = value[sks_pkg::TGT_W-1:0];
      sks_pkg::CFG_PAD_SECOND: model_pad_second = value[sks_pkg::TGT_W-1:0];
      default:                 ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Check each event transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("event with nothing pending, key", int'(m_axis_tdata[5:0]), 0);
      end else begin
        want_ev = pending_events.pop_front();
        if (m_axis_tuser != want_ev.valid)
          report_mismatch("event_valid", m_axis_tuser, want_ev.valid);
        if (m_axis_tdata[5:0] != want_ev.key)
          report_mismatch("key_code", m_axis_tdata[5:0], want_ev.key);
        if (m_axis_tdata[6] != want_ev.pressed)
          report_mismatch("pressed", m_axis_tdata[6], want_ev.pressed);
        if (m_axis_tlast != want_ev.last)
          report_mismatch("last_event", m_axis_tlast, want_ev.last);
      end
    end
  end

  // Edges of the pad, the bands and the grid under the reset register values
  task automatic test_touch_and_pad_edges();
    send_poll(poll_word(12'h000, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
    send_poll(poll_word(12'hFFF, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
    send_poll(poll_word(12'hFFF, 1'b0, 1'b0, 8'd0, 8'd0, 1'b1));
    send_poll(poll_word(12'h000, 1'b0, 1'b1, 8'd0, 8'd0, 1'b1));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd255, 8'd191, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd100, 8'd20, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd100, 8'd21, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd100, 8'd165, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd2, 8'd40, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd3, 8'd37, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd252, 8'd53, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd252, 8'd54, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd253, 8'd40, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd3, 8'd143, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b0, 8'd3, 8'd37, 1'b0));
    // touch the target of A while A is mapped onto it
    send_poll(poll_word(12'h001, 1'b1, 1'b1, 8'd230, 8'd40, 1'b1));
    send_poll(poll_word(12'h000, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
    wait_drain(4);
  endtask

  // Sticky keys: toggle on a fresh touch only, and hold through a release
  task automatic test_sticky_toggle();
    write_reg(sks_pkg::CFG_STICKY, '1);
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd3, 8'd37, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd10, 8'd45, 1'b0));
    send_poll(poll_word(12'h000, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd3, 8'd37, 1'b0));
    send_poll(poll_word(12'h000, 1'b1, 1'b1, 8'd50, 8'd0, 1'b0));
    send_poll(poll_word(12'h000, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0));
    send_poll(poll_word(12'h001, 1'b1, 1'b1, 8'd230, 8'd40, 1'b1));
    send_poll(poll_word(12'h001, 1'b1, 1'b1, 8'd230, 8'd40, 1'b1));
    wait_drain(4);
  endtask

  // Register extremes: no targets, all targets on one key, pad keys as targets
  task automatic test_register_extremes();
    int i;
    write_reg(sks_pkg::CFG_PAD_FIRST, '1);
    write_reg(sks_pkg::CFG_PAD_SECOND, '1);
    for (i = 0; i < 12; i++) send_poll(random_poll());
    wait_drain(4);
    write_reg(sks_pkg::CFG_STICKY, '0);
    write_reg(sks_pkg::CFG_PAD_FIRST, '0);
    write_reg(sks_pkg::CFG_PAD_SECOND, '0);
    for (i = 0; i < 12; i++) send_poll(random_poll());
    wait_drain(4);
    write_reg(sks_pkg::CFG_PAD_FIRST, {6{6'd53}});
    write_reg(sks_pkg::CFG_PAD_SECOND, {6{6'd54}});
    for (i = 0; i < 12; i++) send_poll(random_poll());
    wait_drain(4);
    write_reg(sks_pkg::CFG_STICKY, '1);
    write_reg(sks_pkg::CFG_PAD_FIRST, {6{6'd41}});
    write_reg(sks_pkg::CFG_PAD_SECOND, {6{6'd42}});
    for (i = 0; i < 12; i++) send_poll(random_poll());
    wait_drain(4);
  endtask

  task automatic run_random_phase(input int gap, input int stall, input int count);
    int i;
    write_reg(sks_pkg::CFG_STICKY, sks_pkg::KEY_COUNT'({$urandom, $urandom}));
    write_reg(sks_pkg::CFG_PAD_FIRST, random_targets());
    write_reg(sks_pkg::CFG_PAD_SECOND, random_targets());
    gap_pct   = gap;
    stall_pct = stall;
    for (i = 0; i < count; i++) send_poll(random_poll());
    wait_drain(4);
  endtask

  // Random polls under each mix of sender gaps and receiver stalls
  task automatic test_random_idling();
    run_random_phase(0, 0, 35);
    run_random_phase(61, 0, 35);
    run_random_phase(0, 61, 35);
    run_random_phase(28, 28, 35);
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  // Hold the receiver off while busy polls keep coming, so the input stalls
  task automatic test_output_hold_off();
    int i;
    write_reg(sks_pkg::CFG_STICKY, '0);
    write_reg(sks_pkg::CFG_PAD_FIRST, random_targets());
    write_reg(sks_pkg::CFG_PAD_SECOND, random_targets());
    @(posedge clk_i);
    hold_left = 400;
    for (i = 0; i < 12; i++) begin
      send_poll(poll_word((i % 2 == 0) ? 12'hFFF : 12'h000, 1'b1, 1'b1,
                          8'(sks_pkg::X_LEFT + 1 + i * sks_pkg::COL_PITCH / 2), 8'd40,
                          1'b1));
    end
    wait_drain(4);
  endtask

  // Reset once, then run the tests in turn
  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = sks_pkg::CFG_STICKY;
    cfg_data_i       = '0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    err_count        = 0;
    gap_pct          = 0;
    stall_pct        = 0;
    hold_left        = 0;
    prev_x           = 8'd0;
    prev_y           = 8'd0;
    model_down       = '0;
    model_last_touch = sks_pkg::NO_KEY;
    model_sticky     = '0;
    model_pad_first  = sks_pkg::PAD_FIRST_RESET;
    model_pad_second = sks_pkg::PAD_SECOND_RESET;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_touch_and_pad_edges();
    test_sticky_toggle();
    test_register_extremes();
    test_random_idling();
    test_output_hold_off();

    wait_drain(SETTLE_CYCLES);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
